[src/sil_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg: shared types and constants of the sorted insert list
// Holds the default sizes, the request command codes, the controller state
// encoding and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sil_pkg;

   localparam int CAPACITY_DEF  = 32;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int TAG_WIDTH_DEF = 16;

   // request command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DISPATCH = 5'b00010,
      ST_INS_SCAN = 5'b00100,
      ST_INS_CMP  = 5'b01000,
      ST_FINISH   = 5'b10000
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_req;     // capture request, load scan pointer with count
      logic rd_index;     // read list entry at the request index
      logic rd_prev;      // read list entry just below the scan pointer
      logic write_new;    // write new entry at the scan pointer, bump count
      logic write_shift;  // move the entry read last up to the scan pointer
      logic dec_ptr;      // step the scan pointer down
      logic load_rsp;     // fill the response register
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_read;      // captured request is a read
      logic full;         // list holds CAPACITY entries
      logic ptr_zero;     // scan pointer reached the bottom of the list
      logic key_greater;  // new key is above the key read last
      logic rsp_free;     // response register can take a result this cycle
   } ctrl_status_type;

endpackage

[src/sil_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_ram: generic single-clock RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module sil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sil_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_datapath: storage and data movement of the sorted insert list
// Holds the request, the entry count, the scan pointer, the entry RAM and the
// response register; carries out the commands of the controller.
// ----------------------------------------------------------------------------
module sil_datapath
   import sil_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_command,
   input  logic [KEY_WIDTH-1:0] req_sort_key,
   input  logic [TAG_WIDTH-1:0] req_entry_tag,
   input  logic [4:0]           req_read_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output logic [5:0]           rsp_entry_count,
   output logic                 rsp_read_valid,
   output logic [KEY_WIDTH-1:0] rsp_read_key,
   output logic [TAG_WIDTH-1:0] rsp_read_tag,
   input  ctrl_cmd_type         cmd,
   output ctrl_status_type      status
);

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = KEY_WIDTH + TAG_WIDTH;

   // captured request
   logic                 is_read_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [TAG_WIDTH-1:0] tag_ff;
   logic [4:0]           index_ff;

   // list control
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] ptr_ff, ptr_in;
   logic               stored_ff, stored_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_accepted_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_read_valid_ff;
   logic [KEY_WIDTH-1:0] rsp_key_ff;
   logic [TAG_WIDTH-1:0] rsp_tag_ff;

   // RAM ports
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [TAG_WIDTH-1:0] rd_tag;

   // index and count in a common width
   logic [COUNT_W+4:0]  index_wide;
   logic [COUNT_W+4:0]  count_wide;
   logic [ADDR_W+4:0]   index_addr_wide;
   logic [COUNT_W-1:0]  ptr_prev;
   logic [COUNT_W+5:0]  count_out_wide;
   logic                read_ok;

   assign index_wide      = {{COUNT_W{1'b0}}, index_ff};
   assign count_wide      = {5'b0, count_ff};
   assign index_addr_wide = {{ADDR_W{1'b0}}, index_ff};
   assign ptr_prev        = ptr_ff - COUNT_W'(1);
   assign read_ok         = index_wide < count_wide;

   // capture request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         is_read_ff <= (req_command == CMD_READ);
         key_ff     <= req_sort_key;
         tag_ff     <= req_entry_tag;
         index_ff   <= req_read_index;
      end
   end

   // count, scan pointer and insert flag
   always_comb begin
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      stored_in = stored_ff;
      if (cmd.load_req) begin
         ptr_in    = count_ff;
         stored_in = 1'b0;
      end
      if (cmd.dec_ptr) begin
         ptr_in = ptr_prev;
      end
      if (cmd.write_new) begin
         count_in  = count_ff + COUNT_W'(1);
         stored_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         stored_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         stored_ff <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   // entry RAM: write at the scan pointer, read at the index or below pointer
   assign ram_wr_en   = cmd.write_new | cmd.write_shift;
   assign ram_wr_addr = ptr_ff[ADDR_W-1:0];
   assign ram_wr_data = cmd.write_new ? {key_ff, tag_ff} : ram_rd_data;
   assign ram_rd_en   = cmd.rd_index | cmd.rd_prev;
   assign ram_rd_addr = cmd.rd_index ? index_addr_wide[ADDR_W-1:0]
                                     : ptr_prev[ADDR_W-1:0];

   sil_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key = ram_rd_data[ENTRY_W-1:TAG_WIDTH];
   assign rd_tag = ram_rd_data[TAG_WIDTH-1:0];

   // response register: fill on command, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_accepted_ff   <= stored_ff;
         rsp_count_ff      <= count_ff;
         rsp_read_valid_ff <= is_read_ff & read_ok;
         rsp_key_ff        <= (is_read_ff && read_ok) ? rd_key : '0;
         rsp_tag_ff        <= (is_read_ff && read_ok) ? rd_tag : '0;
      end
   end

   assign count_out_wide  = {6'b0, rsp_count_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_entry_count = count_out_wide[5:0];
   assign rsp_read_valid  = rsp_read_valid_ff;
   assign rsp_read_key    = rsp_key_ff;
   assign rsp_read_tag    = rsp_tag_ff;

   // status to controller
   assign status.is_read     = is_read_ff;
   assign status.full        = (count_ff == COUNT_W'(CAPACITY));
   assign status.ptr_zero    = (ptr_ff == '0);
   assign status.key_greater = key_ff > rd_key;
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   // count stays within the list
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a stored insert raises the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("insert did not bump the count");

endmodule

[src/sil_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_ctrl: sequencer of the sorted insert list
// Accepts one request at a time, steps an insert down from the top of the
// list one entry per pass through scan and compare, and hands the result to the response register.
// ----------------------------------------------------------------------------
module sil_ctrl
   import sil_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (status.is_read) begin
               cmd.rd_index = 1'b1;
               state_in     = ST_FINISH;
            end else if (status.full) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_INS_SCAN;
            end
         end
         ST_INS_SCAN: begin
            if (status.ptr_zero) begin
               cmd.write_new = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (status.key_greater) begin
               cmd.write_new = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.write_shift = 1'b1;
               cmd.dec_ptr     = 1'b1;
               state_in        = ST_INS_SCAN;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // never write a new entry and a shifted entry together
   a_write_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_new && cmd.write_shift))
      else $error("new and shifted entry written together");

   // a placed entry is followed by the result
   a_new_then_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |=> state_ff == ST_FINISH)
      else $error("insert did not move on to result");

   // a result goes out only from the finish state, then back to idle
   a_rsp_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> state_ff == ST_FINISH ##1 state_ff == ST_IDLE)
      else $error("response load outside finish");

endmodule

[src/sorted_insert_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_list_top: bounded list of key and tag entries in ascending key
// Inserts go ahead of the first stored key that is not smaller; reads return
// the entry at an index and the current count.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | command, sort_key, entry_tag,
//          |           |                    | read_index
//  rsp_    | out       | rsp_valid/rsp_stall | accepted, entry_count,
//          |           |                    | read_valid, read_key, read_tag
//
//  One request at a time; req_stall is high from accept until the result is
//  in the response register. A read passes through dispatch to finish. An
//  insert steps down through scan and compare once per shifted entry, reading
//  it and writing it one place up; a rejected insert goes straight to finish.
//  Reset clears the count and the controller; the entry RAM is not cleared.
//  A stalled result is held while the next request is already accepted.
// ----------------------------------------------------------------------------
module sorted_insert_list_top
   import sil_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [KEY_WIDTH-1:0] req_sort_key,
   input  logic [TAG_WIDTH-1:0] req_entry_tag,
   input  logic [4:0]           req_read_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output logic [5:0]           rsp_entry_count,
   output logic                 rsp_read_valid,
   output logic [KEY_WIDTH-1:0] rsp_read_key,
   output logic [TAG_WIDTH-1:0] rsp_read_tag
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   sil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and response
   sil_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_sort_key    (req_sort_key),
      .req_entry_tag   (req_entry_tag),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_entry_count (rsp_entry_count),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_read_key    (rsp_read_key),
      .rsp_read_tag    (rsp_read_tag),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted insert list
// Pushes insert and read requests through the valid/stall channel and keeps a
// shadow copy of the sorted list to predict each response. Every response is
// checked field by field, in order, against the predicted one. The run covers
// idle and stall patterns on both channels and drains between them.
// ----------------------------------------------------------------------------
module tb_top;
   import sil_pkg::*;

   localparam int KW = KEY_WIDTH_DEF;
   localparam int TW = TAG_WIDTH_DEF;

   typedef struct packed {
      logic          cmd;
      logic [KW-1:0] key;
      logic [TW-1:0] tag;
      logic [4:0]    idx;
   } list_request_type;

   typedef struct packed {
      logic          accepted;
      logic [5:0]    count;
      logic          rvalid;
      logic [KW-1:0] rkey;
      logic [TW-1:0] rtag;
   } list_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_command = CMD_INSERT;
   logic [KW-1:0] req_sort_key = '0;
   logic [TW-1:0] req_entry_tag = '0;
   logic [4:0]    req_read_index = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_accepted;
   logic [5:0]    rsp_entry_count;
   logic          rsp_read_valid;
   logic [KW-1:0] rsp_read_key;
   logic [TW-1:0] rsp_read_tag;

   // shadow copy of the list
   logic [KW-1:0] list_keys [CAPACITY_DEF];
   logic [TW-1:0] list_tags [CAPACITY_DEF];
   int            list_count = 0;

   list_request_type pending_requests [$];
   list_result_type  expected_results [$];
   int            requests_issued = 0;
   int            results_checked = 0;
   int            error_count = 0;
   int            req_idle_pct = 0;
   int            rsp_stall_pct = 0;
   logic          req_fire = 1'b0;

   sorted_insert_list_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_sort_key    (req_sort_key),
      .req_entry_tag   (req_entry_tag),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_entry_count (rsp_entry_count),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_read_key    (rsp_read_key),
      .rsp_read_tag    (rsp_read_tag)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one request to the shadow list and return the response it gives
   function automatic list_result_type apply_request(list_request_type r);
      list_result_type res;
      int           pos;
      res = '0;
      if (r.cmd == CMD_INSERT) begin
         if (list_count < CAPACITY_DEF) begin
            pos = 0;
            // equal keys stay behind the new entry
            while (pos < list_count && r.key > list_keys[pos])
               pos++;
            for (int j = list_count; j > pos; j--) begin
               list_keys[j] = list_keys[j-1];
               list_tags[j] = list_tags[j-1];
            end
            list_keys[pos] = r.key;
            list_tags[pos] = r.tag;
            list_count++;
            res.accepted = 1'b1;
         end
      end else if (int'(r.idx) < list_count) begin
         res.rvalid = 1'b1;
         res.rkey   = list_keys[r.idx];
         res.rtag   = list_tags[r.idx];
      end
      res.count = list_count[5:0];
      return res;
   endfunction

   function automatic void report_mismatch(string field, longint unsigned want_val,
                                           longint unsigned got_val);
      $error("%s: expected 0x%0h, got 0x%0h", field, want_val, got_val);
      error_count++;
   endfunction

   // mix of extremes, repeated small keys and full-range keys
   function automatic logic [KW-1:0] pick_key();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return {1'b1, {(KW-1){1'b0}}};
         3: return {1'b0, {(KW-1){1'b1}}};
         4: return KW'($urandom_range(3));
         default: return KW'($urandom);
      endcase
   endfunction

   task automatic queue_request(logic cmd, logic [KW-1:0] key, logic [TW-1:0] tag,
                                logic [4:0] idx);
      pending_requests.push_back({cmd, key, tag, idx});
      requests_issued++;
   endtask

   // spread n_inserts inserts evenly at random over n_items requests
   task automatic queue_random_phase(int n_items, int n_inserts);
      int ins_left;
      ins_left = n_inserts;
      for (int i = 0; i < n_items; i++) begin
         if (ins_left > 0 && $urandom_range(n_items - i - 1) < ins_left) begin
            queue_request(CMD_INSERT, pick_key(), TW'($urandom), 5'($urandom_range(31)));
            ins_left--;
         end else begin
            queue_request(CMD_READ, KW'($urandom), TW'($urandom), 5'($urandom_range(31)));
         end
      end
   endtask

   // present the next request once the current one is taken
   always @(negedge clock) begin
      list_request_type nxt;
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            nxt = pending_requests.pop_front();
            req_valid      <= 1'b1;
            req_command    <= nxt.cmd;
            req_sort_key   <= nxt.key;
            req_entry_tag  <= nxt.tag;
            req_read_index <= nxt.idx;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall the response channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // predict on request accept, check on response accept
   always @(posedge clock) begin
      list_result_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_results.push_back(apply_request({req_command, req_sort_key,
                                                      req_entry_tag, req_read_index}));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("rsp: response with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", want.accepted, rsp_accepted);
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", want.count, rsp_entry_count);
               if (rsp_read_valid !== want.rvalid)
                  report_mismatch("read_valid", want.rvalid, rsp_read_valid);
               if (rsp_read_key !== want.rkey)
                  report_mismatch("read_key", want.rkey, rsp_read_key);
               if (rsp_read_tag !== want.rtag)
                  report_mismatch("read_tag", want.rtag, rsp_read_tag);
               results_checked++;
            end
         end
      end
   end

   // stimulus: eight phases, the idle pattern cycled twice; the list fills
   // over the first four, the last four mostly hit the full list
   initial begin
      int idle_pat  [4];
      int stall_pat [4];
      int fill_plan [4];
      idle_pat  = '{0, 74, 0, 6};
      stall_pat = '{0, 0, 74, 6};
      fill_plan = '{7, 7, 6, 6};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 8; p++) begin
         req_idle_pct  = idle_pat[p % 4];
         rsp_stall_pct = stall_pat[p % 4];
         if (p == 0) begin
            // reads on the empty list
            queue_request(CMD_READ, '1, '1, 5'd0);
            queue_request(CMD_READ, '0, '0, 5'd31);
            // key extremes, equal keys placed newest first
            queue_request(CMD_INSERT, '1, '1, 5'd31);
            queue_request(CMD_INSERT, '0, '0, 5'd0);
            queue_request(CMD_INSERT, 32'h8000_0000, 16'h1111, 5'd5);
            queue_request(CMD_INSERT, 32'h8000_0000, 16'h2222, 5'd10);
            queue_request(CMD_INSERT, '1, 16'h0001, 5'd0);
            queue_request(CMD_INSERT, '0, '1, 5'd0);
            for (int i = 0; i < 6; i++)
               queue_request(CMD_READ, '0, '0, 5'(i));
            // reads past the count
            queue_request(CMD_READ, '0, '0, 5'd6);
            queue_request(CMD_READ, '1, '1, 5'd31);
         end
         queue_random_phase(200, (p < 4) ? fill_plan[p] : 40);
         // hold off until every response is back
         while (results_checked < requests_issued)
            @(negedge clock);
      end

      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
